// File: sv/stli_pkg.sv
`timescale 1ns / 1ps

package stli_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int TABLE_COUNT = 16;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TAB_IDX_W   = $clog2(TABLE_COUNT);
    localparam int TID_W       = 4;
    localparam int CNT_W       = 9;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        MODE_PAIR  = 2'd0,
        MODE_DESC  = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_INTERP   = 2'd0,
        ST_CLAMP_LO = 2'd1,
        ST_CLAMP_HI = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

endpackage

// File: sv/segmented_table_linear_interp_top.sv
// Piecewise linear interpolation over segmented breakpoint tables.
// The input channel (i_in_valid / o_in_ready) carries one transaction per
// command: mode 0 writes a breakpoint pair, mode 1 writes a table descriptor,
// mode 2 interpolates a query in the chosen table and mode 3 is ignored.
// Only a query produces an output transaction (o_out_valid / i_out_ready),
// carrying the Q16.16 result and a status code.
// Writes complete in the cycle they are accepted. A query scans its table one
// breakpoint at a time through the registered store read port (S_RD, then
// S_CMP); a query that clamps then goes to S_OUT, and one on an empty table
// goes there straight from S_IDLE. One that interpolates first passes through
// S_MUL (one 32 by 32 multiply), S_DIV_INIT, a 32-step restoring divider in
// S_DIV and then S_FIN. The block takes one transaction at a time
// and raises o_in_ready again once the result has been handed to the output
// register, so a result left waiting there does not hold up the next input.
// If the receiver stalls, a second query waits in its final state until the
// output register is free. Reset clears all table descriptors, so every table
// reads as empty; the breakpoint store holds no reset value.
`timescale 1ns / 1ps

module segmented_table_linear_interp_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [3:0]  i_table_id,
    input  logic [7:0]  i_entry_address,
    input  logic [31:0] i_entry_x,
    input  logic [31:0] i_entry_y,
    input  logic [7:0]  i_segment_start,
    input  logic [8:0]  i_segment_count,
    input  logic [31:0] i_query_x,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_y_value,
    output logic [1:0]  o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_MUL,
        S_DIV_INIT,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    t_state r_state;

    logic [stli_pkg::DATA_W-1:0] r_mem_x [stli_pkg::STORE_DEPTH];
    logic [stli_pkg::DATA_W-1:0] r_mem_y [stli_pkg::STORE_DEPTH];

    logic [stli_pkg::ADDR_W-1:0] r_tab_start [stli_pkg::TABLE_COUNT];
    logic [stli_pkg::CNT_W-1:0]  r_tab_count [stli_pkg::TABLE_COUNT];

    logic signed [stli_pkg::DATA_W-1:0] r_q;
    logic signed [stli_pkg::DATA_W-1:0] r_rd_x;
    logic signed [stli_pkg::DATA_W-1:0] r_rd_y;
    logic signed [stli_pkg::DATA_W-1:0] r_prev_x;
    logic signed [stli_pkg::DATA_W-1:0] r_prev_y;
    logic signed [stli_pkg::DATA_W-1:0] r_y0;
    logic [stli_pkg::ADDR_W-1:0]        r_addr;
    logic [stli_pkg::CNT_W-1:0]         r_idx;
    logic [stli_pkg::CNT_W-1:0]         r_cnt;
    logic [stli_pkg::DATA_W-1:0]        r_num;
    logic [stli_pkg::DATA_W-1:0]        r_mag;
    logic [stli_pkg::DATA_W-1:0]        r_den;
    logic                               r_neg;
    logic [stli_pkg::PROD_W-1:0]        r_prod;
    logic [stli_pkg::DATA_W-1:0]        r_rem;
    logic [stli_pkg::DATA_W-1:0]        r_quo;
    logic [stli_pkg::DIV_CNT_W-1:0]     r_div_cnt;
    logic [stli_pkg::DATA_W-1:0]        r_res_y;
    stli_pkg::t_status                  r_res_st;
    logic                               r_out_valid;
    logic [stli_pkg::DATA_W-1:0]        r_out_y;
    stli_pkg::t_status                  r_out_st;

    logic                              w_in_acc;
    logic                              w_out_acc;
    logic                              w_tid_ok;
    logic [stli_pkg::TAB_IDX_W-1:0]    w_tid;
    logic [stli_pkg::DATA_W:0]         w_num;
    logic [stli_pkg::DATA_W:0]         w_den;
    logic [stli_pkg::DATA_W:0]         w_dy;
    logic [stli_pkg::DATA_W:0]         w_dy_mag;
    logic [stli_pkg::CNT_W-1:0]        w_idx_inc;
    logic [stli_pkg::DATA_W:0]         w_trial;
    logic [stli_pkg::DATA_W:0]         w_trial_sub;
    logic                              w_trial_ge;
    logic [stli_pkg::DATA_W-1:0]       w_result;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_acc  = r_out_valid && i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_y_value   = r_out_y;
    assign o_status    = r_out_st;

    assign w_tid_ok = (32'(i_table_id) < stli_pkg::TABLE_COUNT);
    assign w_tid    = i_table_id[stli_pkg::TAB_IDX_W-1:0];

    assign w_num    = {r_q[stli_pkg::DATA_W-1], r_q}
                    - {r_prev_x[stli_pkg::DATA_W-1], r_prev_x};
    assign w_den    = {r_rd_x[stli_pkg::DATA_W-1], r_rd_x}
                    - {r_prev_x[stli_pkg::DATA_W-1], r_prev_x};
    assign w_dy     = {r_rd_y[stli_pkg::DATA_W-1], r_rd_y}
                    - {r_prev_y[stli_pkg::DATA_W-1], r_prev_y};
    assign w_dy_mag = w_dy[stli_pkg::DATA_W] ? (~w_dy + 1'b1) : w_dy;
    assign w_idx_inc = r_idx + 1'b1;

    assign w_trial     = {r_rem, r_quo[stli_pkg::DATA_W-1]};
    assign w_trial_sub = w_trial - {1'b0, r_den};
    assign w_trial_ge  = (w_trial >= {1'b0, r_den});

    assign w_result = r_neg ? (r_y0 - r_quo) : (r_y0 + r_quo);

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_mode == stli_pkg::MODE_PAIR)) begin
            r_mem_x[i_entry_address[stli_pkg::ADDR_W-1:0]] <= i_entry_x;
            r_mem_y[i_entry_address[stli_pkg::ADDR_W-1:0]] <= i_entry_y;
        end
        if (r_state == S_RD) begin
            r_rd_x <= r_mem_x[r_addr];
            r_rd_y <= r_mem_y[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int t = 0; t < stli_pkg::TABLE_COUNT; t++) begin
                r_tab_start[t] <= '0;
                r_tab_count[t] <= '0;
            end
        end else begin
            if (w_out_acc && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if ((i_mode == stli_pkg::MODE_DESC) && w_tid_ok) begin
                            r_tab_start[w_tid] <= i_segment_start[stli_pkg::ADDR_W-1:0];
                            r_tab_count[w_tid] <= i_segment_count;
                        end
                        if (i_mode == stli_pkg::MODE_QUERY) begin
                            r_q   <= i_query_x;
                            r_idx <= '0;
                            if (!w_tid_ok || (r_tab_count[w_tid] == '0)) begin
                                r_res_y  <= '0;
                                r_res_st <= stli_pkg::ST_EMPTY;
                                r_state  <= S_OUT;
                            end else begin
                                r_addr  <= r_tab_start[w_tid];
                                r_cnt   <= r_tab_count[w_tid];
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_rd_x >= r_q) begin
                        if (r_idx == '0) begin
                            r_res_y  <= r_rd_y;
                            r_res_st <= stli_pkg::ST_CLAMP_LO;
                            r_state  <= S_OUT;
                        end else begin
                            r_num   <= w_num[stli_pkg::DATA_W-1:0];
                            r_den   <= w_den[stli_pkg::DATA_W-1:0];
                            r_mag   <= w_dy_mag[stli_pkg::DATA_W-1:0];
                            r_neg   <= w_dy[stli_pkg::DATA_W];
                            r_y0    <= r_prev_y;
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_prev_x <= r_rd_x;
                        r_prev_y <= r_rd_y;
                        r_idx    <= w_idx_inc;
                        r_addr   <= r_addr + 1'b1;
                        if (w_idx_inc == r_cnt) begin
                            r_res_y  <= r_rd_y;
                            r_res_st <= stli_pkg::ST_CLAMP_HI;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= r_num * r_mag;
                    r_state <= S_DIV_INIT;
                end
                S_DIV_INIT: begin
                    // The quotient is below 2^32, so the upper half is already
                    // a valid partial remainder.
                    r_rem     <= r_prod[stli_pkg::PROD_W-1:stli_pkg::DATA_W];
                    r_quo     <= r_prod[stli_pkg::DATA_W-1:0];
                    r_div_cnt <= '0;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_trial_ge ? w_trial_sub[stli_pkg::DATA_W-1:0]
                                        : w_trial[stli_pkg::DATA_W-1:0];
                    r_quo <= {r_quo[stli_pkg::DATA_W-2:0], w_trial_ge};
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == stli_pkg::DIV_CNT_W'(stli_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_res_y  <= w_result;
                    r_res_st <= stli_pkg::ST_INTERP;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_y     <= r_res_y;
                        r_out_st    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) || (r_state == S_CMP)) |-> (r_idx < r_cnt))
        else $error("scan index ran past the table count");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below the divisor");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_st == stli_pkg::ST_EMPTY)) |-> (r_out_y == '0))
        else $error("empty table transaction with non-zero result");

    a_empty_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_mode == stli_pkg::MODE_QUERY) && w_tid_ok
            && (r_tab_count[w_tid] == '0)) |=> (r_state == S_OUT))
        else $error("query on empty table did not go straight to output");
`endif

endmodule
